/* hdl/pfmt_pkg.sv */
// ----------------------------------------------------------------------------
// pfmt_pkg
// Shared constants, command/status types and controller states for the
// right-justified signed decimal formatter.
// ----------------------------------------------------------------------------
package pfmt_pkg;

   localparam int DEFAULT_VALUE_BITS = 32;
   localparam int MAX_CHARS          = 16;

   localparam logic [7:0] DIGIT_BASE = 8'h30;  // '0'
   localparam logic [7:0] MINUS_CHAR = 8'h2D;  // '-'
   localparam logic [7:0] SPACE_CHAR = 8'h20;  // ' '

   // CSR address map: register index is paddr[2]
   localparam int          CSR_ADDR_BITS   = 3;
   localparam logic [0:0]  CSR_FIELD_WIDTH = 1'b0;

   typedef struct packed {
      logic load;    // capture a new value, clear the conversion state
      logic shift;   // one binary-to-BCD shift step
      logic size;    // work out padding and character count
      logic emit;    // present one character, advance
   } pfmt_cmd_type;

   typedef struct packed {
      logic conv_done;   // this shift step is the last one
      logic emit_done;   // the character on the output is the final one
   } pfmt_status_type;

   typedef enum logic [3:0] {
      ST_IDLE    = 4'b0001,
      ST_CONVERT = 4'b0010,
      ST_SIZE    = 4'b0100,
      ST_EMIT    = 4'b1000
   } pfmt_state_type;

endpackage

/* hdl/pfmt_ctrl.sv */
// ----------------------------------------------------------------------------
// pfmt_ctrl
// Sequencing state machine: load, convert, size, then emit characters.
// ----------------------------------------------------------------------------
module pfmt_ctrl
   import pfmt_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  pfmt_status_type status,
   output pfmt_cmd_type    cmd
);

   pfmt_state_type state_ff;
   pfmt_state_type state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            cmd.shift = 1'b1;
            if (status.conv_done) begin
               state_in = ST_SIZE;
            end
         end
         ST_SIZE: begin
            cmd.size = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            cmd.emit = 1'b1;
            if (status.emit_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

/* hdl/pfmt_datapath.sv */
// ----------------------------------------------------------------------------
// pfmt_datapath
// Magnitude register, shift-and-add-3 BCD converter, digit count tracking,
// padding arithmetic and character selection.
// ----------------------------------------------------------------------------
module pfmt_datapath
   import pfmt_pkg::*;
#(
   parameter int VALUE_BITS = DEFAULT_VALUE_BITS
)
(
   input  logic                  clock,
   input  logic [VALUE_BITS-1:0] req_value,
   input  logic [4:0]            field_width,
   input  pfmt_cmd_type          cmd,
   output pfmt_status_type       status,
   output logic [7:0]            ascii_char,
   output logic                  last_char
);

   // enough BCD digits for 2**(VALUE_BITS-1): 77/256 bounds log10(2) from below
   localparam int BCD_DIGITS = (VALUE_BITS * 77) / 256 + 1;
   localparam int BCD_BITS   = 4 * BCD_DIGITS;
   localparam int DIG_IDX_W  = $clog2(BCD_DIGITS);
   localparam int ND_W       = $clog2(BCD_DIGITS + 1);
   localparam int BIT_W      = $clog2(VALUE_BITS);
   localparam int TOT_W      = $clog2(BCD_DIGITS + MAX_CHARS + 2);
   localparam int CNT_W      = $clog2(MAX_CHARS + 1);

   logic [VALUE_BITS-1:0] mag_ff;
   logic [BCD_BITS-1:0]   bcd_ff;
   logic [ND_W-1:0]       nd_ff;
   logic                  neg_ff;
   logic [BIT_W-1:0]      bit_ff;
   logic [CNT_W-1:0]      pad_ff;
   logic [CNT_W-1:0]      count_ff;
   logic [TOT_W-1:0]      tot_m1_ff;
   logic [CNT_W-1:0]      k_ff;

   logic [BCD_BITS-1:0]   adj;
   logic [BCD_BITS-1:0]   shifted;
   logic [3:0]            top_digit;
   logic [ND_W-1:0]       nd_in;

   // shift-and-add-3: correct every digit, then shift in the next bit
   always_comb begin
      for (int i = 0; i < BCD_DIGITS; i++) begin
         adj[4*i +: 4] = (bcd_ff[4*i +: 4] >= 4'd5) ? bcd_ff[4*i +: 4] + 4'd3
                                                     : bcd_ff[4*i +: 4];
      end
      shifted = {adj[BCD_BITS-2:0], mag_ff[VALUE_BITS-1]};
      // the digit count grows by at most one per doubling
      top_digit = 4'd0;
      nd_in     = nd_ff;
      if (nd_ff < ND_W'(BCD_DIGITS)) begin
         top_digit = shifted[{nd_ff[DIG_IDX_W-1:0], 2'b00} +: 4];
         if (top_digit != 4'd0) begin
            nd_in = nd_ff + 1'b1;
         end
      end
   end

   logic [TOT_W-1:0] len_t;
   logic [TOT_W-1:0] fw_t;
   logic [TOT_W-1:0] tot_t;
   logic [TOT_W-1:0] pad_t;
   logic [TOT_W-1:0] cnt_t;
   logic [4:0]       fw_eff;

   always_comb begin
      fw_eff = (field_width > 5'(MAX_CHARS)) ? 5'(MAX_CHARS) : field_width;
      fw_t   = TOT_W'(fw_eff);
      len_t  = ((nd_ff == '0) ? TOT_W'(1) : TOT_W'(nd_ff)) + TOT_W'(neg_ff);
      if (fw_t > len_t) begin
         tot_t = fw_t;
         pad_t = fw_t - len_t;
      end else begin
         tot_t = len_t;
         pad_t = '0;
      end
      cnt_t = (tot_t > TOT_W'(MAX_CHARS)) ? TOT_W'(MAX_CHARS) : tot_t;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         neg_ff <= req_value[VALUE_BITS-1];
         mag_ff <= req_value[VALUE_BITS-1] ? (~req_value + 1'b1) : req_value;
         bcd_ff <= '0;
         nd_ff  <= '0;
         bit_ff <= '0;
      end
      if (cmd.shift) begin
         mag_ff <= {mag_ff[VALUE_BITS-2:0], 1'b0};
         bcd_ff <= shifted;
         nd_ff  <= nd_in;
         bit_ff <= bit_ff + 1'b1;
      end
      if (cmd.size) begin
         pad_ff    <= CNT_W'(pad_t);
         count_ff  <= CNT_W'(cnt_t);
         tot_m1_ff <= tot_t - 1'b1;
         k_ff      <= '0;
      end
      if (cmd.emit) begin
         k_ff <= k_ff + 1'b1;
      end
   end

   logic [TOT_W-1:0]     k_t;
   logic [TOT_W-1:0]     pad_w;
   logic [TOT_W-1:0]     didx_t;
   logic [DIG_IDX_W-1:0] didx;
   logic [3:0]           digit;

   // character k: spaces, then sign, then digits counted back from the end
   always_comb begin
      k_t    = TOT_W'(k_ff);
      pad_w  = TOT_W'(pad_ff);
      didx_t = tot_m1_ff - k_t;
      didx   = didx_t[DIG_IDX_W-1:0];
      digit  = bcd_ff[{didx, 2'b00} +: 4];
      if (k_t < pad_w) begin
         ascii_char = SPACE_CHAR;
      end else if (neg_ff && (k_t == pad_w)) begin
         ascii_char = MINUS_CHAR;
      end else begin
         ascii_char = DIGIT_BASE + {4'd0, digit};
      end
   end

   assign last_char        = (CNT_W'(k_ff + 1'b1) == count_ff);
   assign status.emit_done = last_char;
   assign status.conv_done = (bit_ff == BIT_W'(VALUE_BITS - 1));

endmodule

/* hdl/padded_signed_decimal_formatter.sv */
// ----------------------------------------------------------------------------
// padded_signed_decimal_formatter
// Signed integer to right-justified decimal ASCII, one character per cycle.
// The first character follows the BCD shift loop and the sizing step.
// A new value is taken only while idle, after all N characters (1..16) of the last have left.
// Characters leave one per cycle; the receiver cannot stall the output.
// Reset (synchronous, active high) idles the controller and clears field_width.
// ----------------------------------------------------------------------------
module padded_signed_decimal_formatter
   import pfmt_pkg::*;
#(
   parameter int VALUE_BITS = DEFAULT_VALUE_BITS
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [VALUE_BITS-1:0]    req_value,
   output logic                     rsp_strobe,
   output logic [7:0]               rsp_ascii_char,
   output logic                     rsp_last_char,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [31:0]              pwdata,
   output logic [31:0]              prdata,
   output logic                     pready
);

   logic [4:0] field_width_ff;

   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         field_width_ff <= '0;
      end else if (psel && penable && pwrite && pready && (paddr[2] == CSR_FIELD_WIDTH)) begin
         field_width_ff <= pwdata[4:0];
      end
   end

   assign prdata = (paddr[2] == CSR_FIELD_WIDTH) ? {27'd0, field_width_ff} : 32'd0;

   pfmt_cmd_type    cmd;
   pfmt_status_type status;

   pfmt_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   pfmt_datapath #(
      .VALUE_BITS (VALUE_BITS)
   ) u_datapath (
      .clock       (clock),
      .req_value   (req_value),
      .field_width (field_width_ff),
      .cmd         (cmd),
      .status      (status),
      .ascii_char  (rsp_ascii_char),
      .last_char   (rsp_last_char)
   );

   assign rsp_strobe = cmd.emit;

`ifndef SYNTHESIS
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("character strobed while idle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_last_char) |=> !rsp_strobe)
      else $error("character strobed after the last one");

   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last_char) |=> rsp_strobe)
      else $error("gap inside a value's text");
`endif

endmodule
